// File: rtl/ssml_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring match locator package
// Shared widths, register codes, payload types and the letter folding helper.
// ----------------------------------------------------------------------------
package ssml_pkg;

  // Window depth, i.e. the longest query that can be searched for.
  localparam int QUERY_MAX      = 24;

  // Fixed by the register map.
  localparam int QUERY_WORDS    = 6;
  localparam int UNITS_PER_WORD = 4;
  localparam int QUERY_UNITS    = QUERY_WORDS * UNITS_PER_WORD;
  localparam int QUNIT_IDX_W    = $clog2(QUERY_UNITS);
  localparam int WSEL_W         = $clog2(QUERY_WORDS);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int QLEN_W         = 5;

  // Payload field widths.
  localparam int UNIT_W = 16;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 10;
  localparam int WID_W  = 2;
  localparam int ECOL_W = 11;

  // Widths that follow from the window depth.
  localparam int IDX_W  = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int FILL_W = $clog2(QUERY_MAX + 1);

  // Result queue between the matcher and the output stage.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_INSENS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_WORD0 = 3'd2;

  typedef logic [UNIT_W-1:0] unit_t;

  localparam unit_t LF_UNIT           = 16'h000A;
  localparam unit_t CR_UNIT           = 16'h000D;
  localparam unit_t ASCII_UPPER_A     = 16'h0041;
  localparam unit_t ASCII_UPPER_Z     = 16'h005A;
  localparam unit_t ASCII_CASE_OFFSET = 16'h0020;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [WID_W-1:0] wid;
  } loc_t;

  typedef struct packed {
    logic [ROW_W-1:0] start_row;
    logic [COL_W-1:0] start_column;
    logic [ROW_W-1:0] end_row;
    logic [COL_W-1:0] end_column_base;
    logic [WID_W-1:0] end_width;
  } entry_t;

  // Folds ASCII capitals to lower case when enabled; all else passes unchanged.
  function automatic unit_t fold_unit(unit_t u, logic fold_en);
    unit_t r;
    r = u;
    if (fold_en && (u >= ASCII_UPPER_A) && (u <= ASCII_UPPER_Z)) begin
      r = u + ASCII_CASE_OFFSET;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ssml_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring match locator stream interfaces
// Valid/ready channels for text cells in and match locations out.
// ----------------------------------------------------------------------------
interface ssml_in_if import ssml_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [UNIT_W-1:0]  code_unit;
  logic [ROW_W-1:0]   row_index;
  logic [COL_W-1:0]   column_index;
  logic [WID_W-1:0]   cell_width;
  logic               line_start;

  modport source (
    output valid, code_unit, row_index, column_index, cell_width, line_start,
    input  ready
  );
  modport sink (
    input  valid, code_unit, row_index, column_index, cell_width, line_start,
    output ready
  );
endinterface

interface ssml_out_if import ssml_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   start_row;
  logic [COL_W-1:0]   start_column;
  logic [ROW_W-1:0]   end_row;
  logic [ECOL_W-1:0]  end_column;

  modport source (
    output valid, start_row, start_column, end_row, end_column,
    input  ready
  );
  modport sink (
    input  valid, start_row, start_column, end_row, end_column,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/stream_substring_match_locator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Streaming substring match locator
// Reports the start and end cell of every, possibly overlapping, occurrence
// of a configured query in a stream of text code units.
// ----------------------------------------------------------------------------
// The block takes one code unit per clock cycle while its input ready is high. Each accepted unit is
// compared in parallel against the whole query in the cycle of its
// transaction, so the rate is set by that single compare stage; a match is
// written to a four-entry result queue and passes from there into the
// registered output stage. The input ready falls for one cycle after
// each configuration write, while the aligned copy of the query is refreshed,
// and while the result queue is full because the output is stalled.
module stream_substring_match_locator_top import ssml_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ssml_in_if.sink               item_i,
  ssml_out_if.source            match_o
);

  logic   push, full, pop, empty;
  entry_t push_data, head;

  ssml_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ssml_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  ssml_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .match_o (match_o)
  );

endmodule
`default_nettype wire

// File: rtl/ssml_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring match locator front end
// Holds the configuration and the window of recent units, and compares the
// window against the query on every accepted transaction.
// ----------------------------------------------------------------------------
module ssml_front import ssml_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ssml_in_if.sink               item_i,
  input  logic                  full_i,
  output logic                  push_o,
  output entry_t                push_data_o
);

  logic [QLEN_W-1:0]     query_len_q;
  logic                  case_ins_q;
  logic [CFG_DATA_W-1:0] query_word_q [QUERY_WORDS];
  unit_t                 qunit [QUERY_UNITS];

  // Query realigned to window order: entry j is compared with the unit j back.
  unit_t                 qa_d [QUERY_MAX];
  unit_t                 qa_q [QUERY_MAX];
  logic [QUERY_MAX-1:0]  mask_d, mask_q;
  logic                  usable_d, usable_q;
  logic [IDX_W-1:0]      lenm1_d, lenm1_q;
  logic                  cfg_busy_q;

  unit_t                 win_d [QUERY_MAX];
  unit_t                 win_q [QUERY_MAX];
  loc_t                  loc_d [QUERY_MAX];
  loc_t                  loc_q [QUERY_MAX];
  logic [FILL_W-1:0]     fill_d, fill_q;
  logic [QUERY_MAX-1:0]  eq;
  logic                  accept;
  logic                  hit;
  loc_t                  start_loc;

  for (genvar g = 0; g < QUERY_UNITS; g++) begin : g_qunit
    assign qunit[g] =
      query_word_q[g / UNITS_PER_WORD][(g % UNITS_PER_WORD) * UNIT_W +: UNIT_W];
  end

  // Derived query view, refreshed every cycle from the registers.
  always_comb begin
    logic                   brk;
    logic [QUNIT_IDX_W-1:0] idx;
    brk = 1'b0;
    for (int k = 0; k < QUERY_UNITS; k++) begin
      if ((QLEN_W'(k) < query_len_q) && ((qunit[k] == LF_UNIT) || (qunit[k] == CR_UNIT))) begin
        brk = 1'b1;
      end
    end
    usable_d = (query_len_q != '0) && (query_len_q <= QLEN_W'(QUERY_MAX)) && !brk;
    lenm1_d  = IDX_W'(query_len_q - QLEN_W'(1));
    for (int j = 0; j < QUERY_MAX; j++) begin
      mask_d[j] = QLEN_W'(j) < query_len_q;
      idx       = QUNIT_IDX_W'(query_len_q - QLEN_W'(1) - QLEN_W'(j));
      qa_d[j]   = '0;
      if (mask_d[j]) begin
        qa_d[j] = fold_unit(qunit[idx], case_ins_q);
      end
    end
  end

  assign item_i.ready = !full_i && !cfg_busy_q;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    win_d[0] = item_i.code_unit;
    loc_d[0] = '{row: item_i.row_index, col: item_i.column_index, wid: item_i.cell_width};
    for (int j = 1; j < QUERY_MAX; j++) begin
      win_d[j] = win_q[j-1];
      loc_d[j] = loc_q[j-1];
    end
    if (item_i.line_start) begin
      fill_d = FILL_W'(1);
    end else if (fill_q == FILL_W'(QUERY_MAX)) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + FILL_W'(1);
    end
    for (int j = 0; j < QUERY_MAX; j++) begin
      eq[j] = fold_unit(win_d[j], case_ins_q) == qa_q[j];
    end
  end

  assign hit       = usable_q && (QLEN_W'(fill_d) >= query_len_q) && (&(~mask_q | eq));
  assign start_loc = loc_d[lenm1_q];
  assign push_o    = accept && hit;

  assign push_data_o = '{
    start_row:       start_loc.row,
    start_column:    start_loc.col,
    end_row:         loc_d[0].row,
    end_column_base: loc_d[0].col,
    end_width:       loc_d[0].wid
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_len_q <= '0;
      case_ins_q  <= 1'b0;
      for (int w = 0; w < QUERY_WORDS; w++) begin
        query_word_q[w] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_QUERY_LEN:   query_len_q <= cfg_data_i[QLEN_W-1:0];
        CFG_CASE_INSENS: case_ins_q  <= cfg_data_i[0];
        default:         query_word_q[WSEL_W'(cfg_index_i - CFG_QUERY_WORD0)] <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q   <= 1'b0;
      cfg_busy_q <= 1'b0;
      fill_q     <= '0;
    end else begin
      usable_q   <= usable_d;
      cfg_busy_q <= cfg_we_i;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qa_q    <= qa_d;
    mask_q  <= mask_d;
    lenm1_q <= lenm1_d;
    if (accept) begin
      win_q <= win_d;
      loc_q <= loc_d;
    end
  end

  // The derived query view is registered behind the configuration, so no cell may enter in the cycle after a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_we_i |=> !item_i.ready)
    else $error("cell accepted before the query view caught up with a write");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> (fill_d != '0))
    else $error("match reported on an empty line");

endmodule
`default_nettype wire

// File: rtl/ssml_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring match locator result queue
// Small first-in first-out buffer that decouples matching from delivery.
// ----------------------------------------------------------------------------
module ssml_queue import ssml_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t            entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QDEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("result queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("result queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= QCNT_W'(QDEPTH))
    else $error("result queue count out of range");

endmodule
`default_nettype wire

// File: rtl/ssml_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring match locator output stage
// Takes results from the queue, finishes the end column and holds the result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module ssml_back import ssml_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      head_i,
  output logic        pop_o,
  ssml_out_if.source  match_o
);

  logic              valid_q;
  logic [ROW_W-1:0]  start_row_q, end_row_q;
  logic [COL_W-1:0]  start_col_q;
  logic [ECOL_W-1:0] end_col_d, end_col_q;
  logic [WID_W-1:0]  extra;

  assign pop_o = !empty_i && (!valid_q || match_o.ready);

  // A cell of width zero still covers one column.
  assign extra     = (head_i.end_width == '0) ? '0 : head_i.end_width - WID_W'(1);
  assign end_col_d = ECOL_W'(head_i.end_column_base) + ECOL_W'(extra);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (match_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      start_row_q <= head_i.start_row;
      start_col_q <= head_i.start_column;
      end_row_q   <= head_i.end_row;
      end_col_q   <= end_col_d;
    end
  end

  assign match_o.valid        = valid_q;
  assign match_o.start_row    = start_row_q;
  assign match_o.start_column = start_col_q;
  assign match_o.end_row      = end_row_q;
  assign match_o.end_column   = end_col_q;

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substring match locator testbench
// Streams text cells into the locator under several idle and stall patterns,
// predicts every match location from a behavioural copy of the search window
// and checks each reported match field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import ssml_pkg::*;

  localparam int QVEC_W      = QUERY_UNITS * UNIT_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYC  = 8;

  typedef struct packed {
    logic [ROW_W-1:0]  start_row;
    logic [COL_W-1:0]  start_column;
    logic [ROW_W-1:0]  end_row;
    logic [ECOL_W-1:0] end_column;
  } match_loc_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ssml_in_if  cell_ch ();
  ssml_out_if match_ch ();

  stream_substring_match_locator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (cell_ch),
    .match_o     (match_ch)
  );

  // Behavioural copy of the search window and the live configuration.
  unit_t             win_units [QUERY_MAX];
  loc_t              win_locs  [QUERY_MAX];
  int                line_fill;
  logic [QLEN_W-1:0] cur_query_len;
  logic              cur_fold;
  logic [QVEC_W-1:0] cur_query;

  match_loc_t expected_matches [$];

  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned cycle_count;
  logic [ROW_W-1:0] text_row;
  logic [COL_W-1:0] text_col;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d matches outstanding", $time, expected_matches.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    match_ch.ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
  end

  function automatic unit_t fold_letter(unit_t u);
    if (cur_fold && (u >= ASCII_UPPER_A) && (u <= ASCII_UPPER_Z)) begin
      return u + ASCII_CASE_OFFSET;
    end
    return u;
  endfunction

  function automatic unit_t query_at(int k);
    return cur_query[UNIT_W*k +: UNIT_W];
  endfunction

  // Shifts one cell into the window and queues the match it completes, if any.
  function automatic void predict_cell(unit_t u, logic [ROW_W-1:0] row,
                                       logic [COL_W-1:0] col, logic [WID_W-1:0] wid,
                                       logic ls);
    match_loc_t m;
    logic       usable;
    int         len;
    int         i;
    int         k;
    if (ls) begin
      line_fill = 0;
    end
    for (i = QUERY_MAX - 1; i > 0; i--) begin
      win_units[i] = win_units[i-1];
      win_locs[i]  = win_locs[i-1];
    end
    win_units[0] = u;
    win_locs[0]  = {row, col, wid};
    if (line_fill < QUERY_MAX) begin
      line_fill++;
    end
    len    = cur_query_len;
    usable = (len >= 1) && (len <= QUERY_MAX);
    if (usable) begin
      for (k = 0; k < len; k++) begin
        if (query_at(k) == LF_UNIT || query_at(k) == CR_UNIT) begin
          usable = 1'b0;
        end
      end
    end
    if (!usable || line_fill < len) begin
      return;
    end
    for (k = 0; k < len; k++) begin
      if (fold_letter(win_units[len-1-k]) != fold_letter(query_at(k))) begin
        return;
      end
    end
    m.start_row    = win_locs[len-1].row;
    m.start_column = win_locs[len-1].col;
    m.end_row      = win_locs[0].row;
    m.end_column   = {1'b0, win_locs[0].col}
                   + ((win_locs[0].wid == '0) ? 11'd1 : ECOL_W'(win_locs[0].wid)) - 11'd1;
    expected_matches.insert(expected_matches.size(), m);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : match_checker
    match_loc_t want;
    if (rst_ni && match_ch.valid && match_ch.ready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected match: expected none, actual start (%0d,%0d) end (%0d,%0d)",
                 $time, match_ch.start_row, match_ch.start_column,
                 match_ch.end_row, match_ch.end_column);
        error_count++;
      end else begin
        want = expected_matches.pop_front();
        check_field("start_row",    want.start_row,    match_ch.start_row);
        check_field("start_column", want.start_column, match_ch.start_column);
        check_field("end_row",      want.end_row,      match_ch.end_row);
        check_field("end_column",   want.end_column,   match_ch.end_column);
      end
    end
  end

  // Sends one cell, with random idle cycles first, and returns once the
  // transaction has been accepted. Valid is left high for a following cell.
  task automatic send_cell(input unit_t u, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [WID_W-1:0] wid,
                           input logic ls);
    while ($urandom_range(99) < send_idle_pct) begin
      cell_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_ch.valid        <= 1'b1;
    cell_ch.code_unit    <= u;
    cell_ch.row_index    <= row;
    cell_ch.column_index <= col;
    cell_ch.cell_width   <= wid;
    cell_ch.line_start   <= ls;
    @(posedge clk_i);
    while (!cell_ch.ready) begin
      @(posedge clk_i);
    end
    predict_cell(u, row, col, wid, ls);
  endtask

  task automatic wait_for_quiet();
    cell_ch.valid <= 1'b0;
    while (expected_matches.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Writes every register once the block has gone quiet.
  task automatic apply_config(input int len, input logic fold, input logic [QVEC_W-1:0] q);
    int w;
    wait_for_quiet();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_QUERY_LEN;
    cfg_data_i  <= CFG_DATA_W'(len[QLEN_W-1:0]);
    @(posedge clk_i);
    cur_query_len = len[QLEN_W-1:0];
    cfg_index_i <= CFG_CASE_INSENS;
    cfg_data_i  <= CFG_DATA_W'(fold);
    @(posedge clk_i);
    cur_fold = fold;
    for (w = 0; w < QUERY_WORDS; w++) begin
      cfg_index_i <= CFG_QUERY_WORD0 + CFG_IDX_W'(w);
      cfg_data_i  <= q[CFG_DATA_W*w +: CFG_DATA_W];
      @(posedge clk_i);
      cur_query[CFG_DATA_W*w +: CFG_DATA_W] = q[CFG_DATA_W*w +: CFG_DATA_W];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_disabled_query();
    apply_config(0, 1'b0, '0);
    send_cell(16'h0000, 16'd0, 10'd0, 2'd0, 1'b1);
    send_cell(16'h0000, 16'd0, 10'd1, 2'd0, 1'b0);
  endtask

  // Overlapping matches on repeated units, with rows, columns and widths at
  // their extremes, and a line start that cuts a match short.
  task automatic test_overlap_and_extremes();
    apply_config(2, 1'b0, '1);
    send_cell(16'hFFFF, 16'h0000, 10'h000, 2'd0, 1'b1);
    send_cell(16'hFFFF, 16'hFFFF, 10'h3FF, 2'd3, 1'b0);
    send_cell(16'hFFFF, 16'h1234, 10'h200, 2'd2, 1'b0);
    send_cell(16'hFFFF, 16'h0000, 10'h005, 2'd1, 1'b1);
    send_cell(16'hFFFF, 16'h0000, 10'h006, 2'd0, 1'b0);
  endtask

  // Query "@aZ": folding must touch letters only, so a backquote never
  // stands in for the at sign.
  task automatic test_case_folding();
    logic [QVEC_W-1:0] q;
    q = '0;
    q[0*UNIT_W +: UNIT_W] = 16'h0040;
    q[1*UNIT_W +: UNIT_W] = 16'h0061;
    q[2*UNIT_W +: UNIT_W] = 16'h005A;
    apply_config(3, 1'b1, q);
    send_cell(16'h0060, 16'd7, 10'd0, 2'd1, 1'b1);
    send_cell(16'h0041, 16'd7, 10'd1, 2'd1, 1'b0);
    send_cell(16'h007A, 16'd7, 10'd2, 2'd1, 1'b0);
    send_cell(16'h0040, 16'd7, 10'd3, 2'd1, 1'b0);
    send_cell(16'h0041, 16'd7, 10'd4, 2'd1, 1'b0);
    send_cell(16'h007A, 16'd7, 10'd5, 2'd1, 1'b0);
    apply_config(3, 1'b0, q);
    send_cell(16'h0040, 16'd8, 10'd0, 2'd1, 1'b1);
    send_cell(16'h0041, 16'd8, 10'd1, 2'd1, 1'b0);
    send_cell(16'h007A, 16'd8, 10'd2, 2'd1, 1'b0);
    send_cell(16'h0040, 16'd8, 10'd3, 2'd1, 1'b0);
    send_cell(16'h0061, 16'd8, 10'd4, 2'd1, 1'b0);
    send_cell(16'h005A, 16'd8, 10'd5, 2'd1, 1'b0);
  endtask

  // A line feed or carriage return inside the query disables it; one just
  // past the query length does not.
  task automatic test_line_breaks_in_query();
    logic [QVEC_W-1:0] q;
    q = '0;
    q[0*UNIT_W +: UNIT_W] = LF_UNIT;
    q[1*UNIT_W +: UNIT_W] = 16'h0078;
    apply_config(2, 1'b0, q);
    send_cell(LF_UNIT, 16'd9, 10'd0, 2'd1, 1'b1);
    send_cell(16'h0078, 16'd9, 10'd1, 2'd1, 1'b0);
    q[0*UNIT_W +: UNIT_W] = 16'h0078;
    q[1*UNIT_W +: UNIT_W] = CR_UNIT;
    apply_config(2, 1'b0, q);
    send_cell(16'h0078, 16'd9, 10'd2, 2'd1, 1'b0);
    send_cell(CR_UNIT, 16'd9, 10'd3, 2'd1, 1'b0);
    q[1*UNIT_W +: UNIT_W] = 16'h0079;
    q[2*UNIT_W +: UNIT_W] = LF_UNIT;
    apply_config(2, 1'b0, q);
    send_cell(16'h0078, 16'd9, 10'd4, 2'd1, 1'b0);
    send_cell(16'h0079, 16'd9, 10'd5, 2'd1, 1'b0);
  endtask

  task automatic test_oversized_query();
    logic [QVEC_W-1:0] q;
    q = {QUERY_UNITS{16'h0071}};
    apply_config(31, 1'b0, q);
    send_cell(16'h0071, 16'd10, 10'd0, 2'd1, 1'b1);
    send_cell(16'h0071, 16'd10, 10'd1, 2'd1, 1'b0);
    send_cell(16'h0071, 16'd10, 10'd2, 2'd1, 1'b0);
  endtask

  // One query setting, then a stream that mostly plants the query (with
  // random case flips when folding) among units drawn from it, letters and
  // arbitrary values. Line starts fall at random and break some occurrences.
  task automatic run_random_segment(input int forced_len, input int n_cells);
    logic [QVEC_W-1:0] q;
    int                len;
    int                live_len;
    int                pick;
    int                pos;
    int                k;
    int                n;
    int                adv;
    logic              fold;
    logic              ls;
    logic [WID_W-1:0]  wid;
    unit_t             u;
    pick = $urandom_range(99);
    if (forced_len >= 0) begin
      len = forced_len;
    end else if (pick < 5) begin
      len = 0;
    end else if (pick < 10) begin
      len = $urandom_range(31, QUERY_MAX + 1);
    end else if (pick < 25) begin
      len = $urandom_range(QUERY_MAX, 7);
    end else begin
      len = $urandom_range(6, 1);
    end
    fold = 1'($urandom_range(1));
    for (k = 0; k < QUERY_UNITS; k++) begin
      pick = $urandom_range(99);
      if (k >= len) begin
        q[UNIT_W*k +: UNIT_W] = UNIT_W'($urandom_range(16'hFFFF));
      end else if (pick < 60) begin
        q[UNIT_W*k +: UNIT_W] = UNIT_W'((pick < 30 ? 16'h0061 : 16'h0041) + $urandom_range(2));
      end else if (pick < 85) begin
        q[UNIT_W*k +: UNIT_W] = UNIT_W'($urandom_range(16'h007E, 16'h0020));
      end else begin
        q[UNIT_W*k +: UNIT_W] = UNIT_W'($urandom_range(16'hFFFF));
      end
    end
    if (len >= 1 && len <= QUERY_MAX && $urandom_range(19) == 0) begin
      q[UNIT_W*$urandom_range(len - 1) +: UNIT_W] = $urandom_range(1) ? LF_UNIT : CR_UNIT;
    end
    apply_config(len, fold, q);
    live_len = (len >= 1 && len <= QUERY_MAX) ? len : 0;
    pos = -1;
    for (n = 0; n < n_cells; n++) begin
      ls = ($urandom_range(29) == 0);
      if (pos < 0 && live_len > 0 && $urandom_range(99) < 25) begin
        pos = 0;
      end
      if (pos >= 0) begin
        u = q[UNIT_W*pos +: UNIT_W];
        if (fold && $urandom_range(1) &&
            ((u >= 16'h0041 && u <= 16'h005A) || (u >= 16'h0061 && u <= 16'h007A))) begin
          u = u ^ ASCII_CASE_OFFSET;
        end
        pos++;
        if (pos == live_len) begin
          pos = -1;
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 50 && live_len > 0) begin
          u = q[UNIT_W*$urandom_range(live_len - 1) +: UNIT_W];
        end else if (pick < 80) begin
          u = UNIT_W'($urandom_range(16'h007A, 16'h0041));
        end else begin
          u = UNIT_W'($urandom_range(16'hFFFF));
        end
      end
      wid = WID_W'($urandom_range(3));
      if ($urandom_range(49) == 0) begin
        text_row = ROW_W'($urandom_range(16'hFFFF));
        text_col = COL_W'($urandom_range(10'h3FF));
      end
      send_cell(u, text_row, text_col, wid, ls);
      adv = (wid == '0) ? 1 : int'(wid);
      if (int'(text_col) + adv > 1023) begin
        text_col = '0;
        text_row = text_row + 1'b1;
      end else begin
        text_col = text_col + COL_W'(adv);
      end
    end
  endtask

  // The first two settings of each phase pin the longest and shortest query.
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_cells);
    int sent;
    int seg;
    int seg_len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    seg  = 0;
    while (sent < n_cells) begin
      seg_len = $urandom_range(110, 30);
      if (seg_len > n_cells - sent) begin
        seg_len = n_cells - sent;
      end
      run_random_segment(seg == 0 ? QUERY_MAX : (seg == 1 ? 1 : -1), seg_len);
      sent += seg_len;
      seg++;
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = '0;
    cfg_data_i           = '0;
    cell_ch.valid        = 1'b0;
    cell_ch.code_unit    = '0;
    cell_ch.row_index    = '0;
    cell_ch.column_index = '0;
    cell_ch.cell_width   = '0;
    cell_ch.line_start   = 1'b0;
    match_ch.ready       = 1'b0;
    error_count          = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    cycle_count          = 0;
    line_fill            = 0;
    cur_query_len        = '0;
    cur_fold             = 1'b0;
    cur_query            = '0;
    text_row             = '0;
    text_col             = '0;
    for (int i = 0; i < QUERY_MAX; i++) begin
      win_units[i] = '0;
      win_locs[i]  = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_disabled_query();
    test_overlap_and_extremes();
    test_case_folding();
    test_line_breaks_in_query();
    test_oversized_query();
    test_random_phase(0, 0, 388);
    test_random_phase(67, 0, 388);
    test_random_phase(0, 67, 388);
    test_random_phase(25, 25, 388);

    wait_for_quiet();
    if (error_count == 0 && expected_matches.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
